// ===== rtl/tac_pkg.sv =====
// Package for the trajectory alignment check block: widths, codes, item and
// configuration structs, and the back-end sequencer states.
// No dependencies; every other rtl file imports it.
package tac_pkg;

   localparam int COORD_W = 32;
   localparam int QUAT_W = 18;
   localparam int QUAT_FRAC = 16;
   localparam int QPROD_W = 36;
   localparam int COEF_W = 22;
   localparam int MUL_A_W = 22;
   localparam int MUL_B_W = 33;
   localparam int PROD_W = 55;
   localparam int SHIFT_SUM_W = 40;
   localparam int SQ_PART_W = 48;
   localparam int RAD_W = 66;
   localparam int ROOT_W = 33;
   localparam int REM_W = 35;
   localparam int ROOT_STEPS = 33;
   localparam int ROOT_CNT_W = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int QUAT_PRODS = 9;
   localparam int ROT_PRODS = 6;
   localparam int SQ_PRODS = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int PATH_WIDTH_DEFAULT = 40;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROT_W,
      CSR_ROT_X,
      CSR_ROT_Y,
      CSR_ROT_Z,
      CSR_SHIFT_EAST,
      CSR_SHIFT_NORTH
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] map_x;
      logic [COORD_W-1:0] map_y;
      logic [COORD_W-1:0] map_z;
      logic [COORD_W-1:0] gnss_east;
      logic [COORD_W-1:0] gnss_north;
      logic               first_item;
      logic               last_item;
   } tac_item_type;

   typedef struct packed {
      logic               valid;
      tac_item_type       item;
   } tac_push_type;

   typedef struct packed {
      logic [QUAT_W-1:0]  rot_w;
      logic [QUAT_W-1:0]  rot_x;
      logic [QUAT_W-1:0]  rot_y;
      logic [QUAT_W-1:0]  rot_z;
      logic [COORD_W-1:0] shift_east;
      logic [COORD_W-1:0] shift_north;
   } tac_cfg_type;

   typedef struct packed {
      logic               start;
      logic [RAD_W-1:0]   radicand;
   } tac_root_req_type;

   typedef struct packed {
      logic               done;
      logic [ROOT_W-1:0]  root;
   } tac_root_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUAT,
      ST_COEF,
      ST_ROT,
      ST_ROT_SUM,
      ST_SHIFT,
      ST_DIFF,
      ST_SQ,
      ST_SQ_SUM,
      ST_DEV_ROOT,
      ST_STEP_ROOT,
      ST_DECIDE
   } back_state_type;

endpackage

// ===== rtl/tac_front.sv =====
// Front end: a one-beat input buffer that takes request beats and unpacks
// them into item structs for the queue. Depends on tac_pkg.
module tac_front
   import tac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,
   input  logic         req_tuser,
   input  logic         req_tlast,
   output tac_push_type push,
   input  logic         push_ready
);

   logic         buf_valid_ff, buf_valid_in;
   tac_item_type buf_item_ff;
   logic         accept;

   assign req_tready = !buf_valid_ff || push_ready;
   assign accept = req_tvalid && req_tready;
   assign buf_valid_in = accept || (buf_valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_item_ff.map_x      <= req_tdata[31:0];
         buf_item_ff.map_y      <= req_tdata[63:32];
         buf_item_ff.map_z      <= req_tdata[95:64];
         buf_item_ff.gnss_east  <= req_tdata[127:96];
         buf_item_ff.gnss_north <= req_tdata[159:128];
         buf_item_ff.first_item <= req_tuser;
         buf_item_ff.last_item  <= req_tlast;
      end
   end

   assign push.valid = buf_valid_ff;
   assign push.item = buf_item_ff;

endmodule

// ===== rtl/tac_fifo.sv =====
// Short queue of items between the front end and the back-end sequencer.
// Depends on tac_pkg.
module tac_fifo
   import tac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  tac_push_type push,
   output logic         push_ready,
   output logic         pop_valid,
   output tac_item_type pop_item,
   input  logic         pop
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   tac_item_type   mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item = mem_ff[rd_ptr_ff];
   assign do_push = push.valid && push_ready;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

// ===== rtl/tac_root.sv =====
// Iterative floored square root, two radicand bits per cycle (restoring
// digit recurrence). Depends on tac_pkg.
module tac_root
   import tac_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  tac_root_req_type req,
   output tac_root_rsp_type rsp
);

   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic                  fits;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial = {root_ff, 2'b01};
   assign fits = (rem_sh >= trial);

   always_comb begin
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rad_in = req.radicand;
         rem_in = '0;
         root_in = '0;
         cnt_in = ROOT_CNT_W'(ROOT_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         rem_in = fits ? rem_sh - trial : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ROOT_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

// ===== rtl/tac_back.sv =====
// Back end: sequencer that carries out one item over many cycles with one
// shared 22x33 multiplier, the shared root unit and the run state.
// Depends on tac_pkg; drives tac_root through the request struct.
module tac_back
   import tac_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int PATH_WIDTH = PATH_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  tac_cfg_type      cfg,
   input  logic             fifo_valid,
   input  tac_item_type     fifo_item,
   output logic             fifo_pop,
   output tac_root_req_type root_req,
   input  tac_root_rsp_type root_rsp,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_deviates,
   output logic             rsp_failed,
   output logic             rsp_done
);

   localparam int CW = (PATH_WIDTH > ROOT_W + 1) ? PATH_WIDTH : ROOT_W + 1;
   localparam int SW = 2 * COORD_W + 1;

   back_state_type state_ff, state_in;
   logic [3:0]     cnt_ff, cnt_in;
   tac_item_type   item_ff;

   logic signed [QPROD_W-1:0]     qp_ff [QUAT_PRODS];
   logic signed [COEF_W-1:0]      c_ff [ROT_PRODS];
   logic signed [PROD_W-1:0]      rp_ff [ROT_PRODS];
   logic signed [PROD_W-1:0]      sum_e_ff, sum_n_ff;
   logic signed [COORD_W-1:0]     e_ff, n_ff;
   logic [COORD_W-1:0]            dabs_ff [4];
   logic [SQ_PART_W-1:0]          sqp_ff [SQ_PRODS];
   logic [SW-1:0]                 s_dev_ff, s_step_ff;
   logic [ROOT_W-1:0]             dev_ff;
   logic [PATH_WIDTH-1:0]         path_ff;
   logic [COORD_W-1:0]            prev_x_ff, prev_y_ff;
   logic                          failed_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_dev_ff, rsp_fail_ff, rsp_last_ff;

   logic signed [MUL_A_W-1:0]     mul_a;
   logic signed [MUL_B_W-1:0]     mul_b;
   logic signed [PROD_W-1:0]      prod;
   logic signed [QUAT_W-1:0]      qa, qb;
   logic [COORD_W-1:0]            pick_p, da;
   logic [15:0]                   half;
   logic signed [37:0]            num [ROT_PRODS];
   logic signed [SHIFT_SUM_W-1:0] te, tn;
   logic signed [COORD_W:0]       dif [4];
   logic [PATH_WIDTH:0]           path_sum;
   logic [PATH_WIDTH-1:0]         path_new;
   logic                          deviates;
   logic                          out_free, out_load;

   function automatic logic [COORD_W-1:0] sat32(input logic signed [SHIFT_SUM_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v > $signed({{(SHIFT_SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}})) begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (v < $signed({{(SHIFT_SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}})) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] abs33(input logic signed [COORD_W:0] v);
      logic signed [COORD_W:0] m;
      m = v[COORD_W] ? -v : v;
      return m[COORD_W-1:0];
   endfunction

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (fifo_valid) state_in = ST_QUAT;
         end
         ST_QUAT: begin
            if (cnt_ff == 4'(QUAT_PRODS - 1)) state_in = ST_COEF;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_COEF: state_in = ST_ROT;
         ST_ROT: begin
            if (cnt_ff == 4'(ROT_PRODS - 1)) state_in = ST_ROT_SUM;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_ROT_SUM: state_in = ST_SHIFT;
         ST_SHIFT: state_in = ST_DIFF;
         ST_DIFF: state_in = ST_SQ;
         ST_SQ: begin
            if (cnt_ff == 4'(SQ_PRODS - 1)) state_in = ST_SQ_SUM;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_SQ_SUM: state_in = ST_DEV_ROOT;
         ST_DEV_ROOT: begin
            if (root_rsp.done) state_in = ST_STEP_ROOT;
            else cnt_in = 4'd1;
         end
         ST_STEP_ROOT: begin
            if (root_rsp.done) state_in = ST_DECIDE;
            else cnt_in = 4'd1;
         end
         ST_DECIDE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: pop, root start, multiplier operands, result load.
   always_comb begin
      fifo_pop = (state_ff == ST_IDLE) && fifo_valid;
      root_req.start = ((state_ff == ST_DEV_ROOT) || (state_ff == ST_STEP_ROOT))
                       && (cnt_ff == '0);
      root_req.radicand = (state_ff == ST_STEP_ROOT) ? RAD_W'(s_step_ff) : RAD_W'(s_dev_ff);
      out_load = (state_ff == ST_DECIDE) && out_free;
      qa = $signed(cfg.rot_w);
      qb = $signed(cfg.rot_x);
      case (cnt_ff)
         4'd0: begin qa = $signed(cfg.rot_y); qb = $signed(cfg.rot_y); end
         4'd1: begin qa = $signed(cfg.rot_z); qb = $signed(cfg.rot_z); end
         4'd2: begin qa = $signed(cfg.rot_x); qb = $signed(cfg.rot_y); end
         4'd3: begin qa = $signed(cfg.rot_w); qb = $signed(cfg.rot_z); end
         4'd4: begin qa = $signed(cfg.rot_x); qb = $signed(cfg.rot_z); end
         4'd5: begin qa = $signed(cfg.rot_w); qb = $signed(cfg.rot_y); end
         4'd6: begin qa = $signed(cfg.rot_x); qb = $signed(cfg.rot_x); end
         4'd7: begin qa = $signed(cfg.rot_y); qb = $signed(cfg.rot_z); end
         default: begin qa = $signed(cfg.rot_w); qb = $signed(cfg.rot_x); end
      endcase
      case (cnt_ff)
         4'd0, 4'd3: pick_p = item_ff.map_x;
         4'd1, 4'd4: pick_p = item_ff.map_y;
         default:    pick_p = item_ff.map_z;
      endcase
      da = dabs_ff[cnt_ff[2:1]];
      half = cnt_ff[0] ? da[15:0] : da[31:16];
      case (state_ff)
         ST_QUAT: begin
            mul_a = MUL_A_W'(qa);
            mul_b = MUL_B_W'(qb);
         end
         ST_ROT: begin
            mul_a = c_ff[cnt_ff[2:0]];
            mul_b = MUL_B_W'($signed(pick_p));
         end
         default: begin
            mul_a = {{(MUL_A_W-16){1'b0}}, half};
            mul_b = {1'b0, da};
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Rotation matrix numerators in Q.32, floored to Q.16 coefficients.
   always_comb begin
      num[0] = 38'sh01_0000_0000 - ((38'(qp_ff[0]) + 38'(qp_ff[1])) <<< 1);
      num[1] = (38'(qp_ff[2]) - 38'(qp_ff[3])) <<< 1;
      num[2] = (38'(qp_ff[4]) + 38'(qp_ff[5])) <<< 1;
      num[3] = (38'(qp_ff[2]) + 38'(qp_ff[3])) <<< 1;
      num[4] = 38'sh01_0000_0000 - ((38'(qp_ff[6]) + 38'(qp_ff[1])) <<< 1);
      num[5] = (38'(qp_ff[7]) - 38'(qp_ff[8])) <<< 1;
      te = SHIFT_SUM_W'(sum_e_ff >>> QUAT_FRAC) + SHIFT_SUM_W'($signed(cfg.shift_east));
      tn = SHIFT_SUM_W'(sum_n_ff >>> QUAT_FRAC) + SHIFT_SUM_W'($signed(cfg.shift_north));
      dif[0] = (COORD_W+1)'(e_ff) - (COORD_W+1)'($signed(item_ff.gnss_east));
      dif[1] = (COORD_W+1)'(n_ff) - (COORD_W+1)'($signed(item_ff.gnss_north));
      dif[2] = (COORD_W+1)'($signed(item_ff.map_x)) - (COORD_W+1)'($signed(prev_x_ff));
      dif[3] = (COORD_W+1)'($signed(item_ff.map_y)) - (COORD_W+1)'($signed(prev_y_ff));
   end

   // Path update and the deviation rule: 2 * dev > path once path > 2 m.
   // The path register already holds this item's step when the rule is applied.
   always_comb begin
      path_sum = {1'b0, path_ff} + (PATH_WIDTH+1)'(root_rsp.root);
      path_new = path_sum[PATH_WIDTH] ? '1 : path_sum[PATH_WIDTH-1:0];
      deviates = (CW'(path_ff) > (CW'(1) << (FRAC_BITS + 1)))
                 && ((CW'(dev_ff) << 1) > CW'(path_ff));
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         path_ff <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         failed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fifo_pop && fifo_item.first_item) begin
            path_ff <= '0;
            prev_x_ff <= '0;
            prev_y_ff <= '0;
            failed_ff <= 1'b0;
         end else if (state_ff == ST_STEP_ROOT && root_rsp.done) begin
            path_ff <= path_new;
            prev_x_ff <= item_ff.map_x;
            prev_y_ff <= item_ff.map_y;
         end else if (out_load) begin
            failed_ff <= failed_ff || deviates;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_pop) item_ff <= fifo_item;
      case (state_ff)
         ST_QUAT: qp_ff[cnt_ff] <= prod[QPROD_W-1:0];
         ST_COEF: begin
            for (int i = 0; i < ROT_PRODS; i++) begin
               c_ff[i] <= COEF_W'(num[i] >>> QUAT_FRAC);
            end
         end
         ST_ROT: rp_ff[cnt_ff[2:0]] <= prod;
         ST_ROT_SUM: begin
            sum_e_ff <= rp_ff[0] + rp_ff[1] + rp_ff[2];
            sum_n_ff <= rp_ff[3] + rp_ff[4] + rp_ff[5];
         end
         ST_SHIFT: begin
            e_ff <= sat32(te);
            n_ff <= sat32(tn);
         end
         ST_DIFF: begin
            for (int i = 0; i < 4; i++) begin
               dabs_ff[i] <= abs33(dif[i]);
            end
         end
         ST_SQ: sqp_ff[cnt_ff[2:0]] <= prod[SQ_PART_W-1:0];
         ST_SQ_SUM: begin
            s_dev_ff <= (SW'(sqp_ff[0]) << 16) + SW'(sqp_ff[1])
                        + (SW'(sqp_ff[2]) << 16) + SW'(sqp_ff[3]);
            s_step_ff <= (SW'(sqp_ff[4]) << 16) + SW'(sqp_ff[5])
                         + (SW'(sqp_ff[6]) << 16) + SW'(sqp_ff[7]);
         end
         ST_DEV_ROOT: begin
            if (root_rsp.done) dev_ff <= root_rsp.root;
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_dev_ff <= deviates;
         rsp_fail_ff <= failed_ff || deviates;
         rsp_last_ff <= item_ff.last_item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_deviates = rsp_dev_ff;
   assign rsp_failed = rsp_fail_ff;
   assign rsp_done = rsp_last_ff;

endmodule

// ===== rtl/trajectory_alignment_check_unit.sv =====
// Top level of the trajectory alignment check: configuration registers and
// the front end, item queue, back-end sequencer and root unit.
// Depends on tac_pkg, tac_front, tac_fifo, tac_root and tac_back.
//
// Usage: each req beat carries one map pose and one GNSS east/north fix.
// The map position is rotated by the configured quaternion, shifted by the
// configured east/north offset, and its horizontal distance to the fix is
// compared against half of the run's accumulated path length.
// Channels: req (stream in, tuser starts a new run, tlast ends it), rsp
// (stream out, one beat per req beat, tlast copies the req tlast), and csr
// (register index and data, always ready). The user must write csr only
// while idle; the block itself does not enforce it. The back end works on
// one item at a time and takes the next only when it is through with the
// one before: the shared 22x33 multiplier takes 23 products in turn, and
// each of the two distances goes through the root unit (start, 33 steps,
// done). The front end and a two-entry queue keep taking beats while the
// back end works, so up to three items can wait ahead of it.
// Reset clears the run state (path, previous position, failure flag), the
// queue and the output register, and loads the identity rotation and zero
// offset. When the receiver stalls, the finished result holds in the output
// register; the back end finishes its next item and waits for that register.
module trajectory_alignment_check_unit
   import tac_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int PATH_WIDTH = PATH_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // map_x, map_y, map_z, gnss_east, gnss_north, 32 bits each from bit 0 up
   input  logic [159:0]           req_tdata,
   // first_item
   input  logic                   req_tuser,
   // last_item
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // item_deviates, run_failed, then six zero bits
   output logic [7:0]             rsp_tdata,
   // run_done
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   tac_cfg_type      cfg_ff;
   tac_push_type     push;
   logic             push_ready;
   logic             fifo_valid, fifo_pop;
   tac_item_type     fifo_item;
   tac_root_req_type root_req;
   tac_root_rsp_type root_rsp;
   logic             deviates, failed;

   assign csr_ready = 1'b1;

   // Register file; writes to indexes past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_w <= QUAT_W'(65536);
         cfg_ff.rot_x <= '0;
         cfg_ff.rot_y <= '0;
         cfg_ff.rot_z <= '0;
         cfg_ff.shift_east <= '0;
         cfg_ff.shift_north <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROT_W:       cfg_ff.rot_w <= csr_data[QUAT_W-1:0];
            CSR_ROT_X:       cfg_ff.rot_x <= csr_data[QUAT_W-1:0];
            CSR_ROT_Y:       cfg_ff.rot_y <= csr_data[QUAT_W-1:0];
            CSR_ROT_Z:       cfg_ff.rot_z <= csr_data[QUAT_W-1:0];
            CSR_SHIFT_EAST:  cfg_ff.shift_east <= csr_data;
            CSR_SHIFT_NORTH: cfg_ff.shift_north <= csr_data;
            default: ;
         endcase
      end
   end

   tac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_ready (push_ready)
   );

   tac_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (fifo_valid),
      .pop_item   (fifo_item),
      .pop        (fifo_pop)
   );

   tac_root u_root (
      .clock (clock),
      .reset (reset),
      .req   (root_req),
      .rsp   (root_rsp)
   );

   tac_back #(
      .FRAC_BITS  (FRAC_BITS),
      .PATH_WIDTH (PATH_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .fifo_valid   (fifo_valid),
      .fifo_item    (fifo_item),
      .fifo_pop     (fifo_pop),
      .root_req     (root_req),
      .root_rsp     (root_rsp),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_deviates (deviates),
      .rsp_failed   (failed),
      .rsp_done     (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, failed, deviates};

endmodule

// ===== rtl/tac_checker.sv =====
// Port-level checks for the trajectory alignment check unit, bound to the
// top level. Depends on tac_pkg and trajectory_alignment_check_unit.
module tac_checker
   import tac_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [7:0]             rsp_tdata,
   input logic                   rsp_tlast,
   input logic                   csr_ready
);

   // A stalled result beat keeps its content.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp beat changed");

   // A deviating pair always reports a failed run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[0] || rsp_tdata[1])
      else $error("deviation without run failure");

   // Padding bits of the result stay zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:2] == 6'b0)
      else $error("rsp padding not zero");

   // No result right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // Register writes are never held off.
   assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr not ready");

endmodule

bind trajectory_alignment_check_unit tac_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);
